// ===== rtl/core/matrix_invert_3x3_top_macros.svh =====
// ---------------------------------------------------------------------------
// matrix_invert_3x3_top_macros
// Assertion macros used by the matrix inverter top level.
// ---------------------------------------------------------------------------
`ifndef MATRIX_INVERT_3X3_TOP_MACROS_SVH
`define MATRIX_INVERT_3X3_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on every edge outside reset
`define MI3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define MI3_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MI3_ASSERT(lbl, clk, rst, prop, msg)
`define MI3_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/mi3_pkg.sv =====
// ---------------------------------------------------------------------------
// mi3_pkg
// Types, widths and latencies of the 3x3 matrix inverter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mi3_pkg;

   localparam int ELEM_WIDTH        = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int THRESH_WIDTH      = 32;
   localparam int THRESH_FRAC       = 16;
   localparam int CMAG_WIDTH        = 2 * ELEM_WIDTH;
   localparam int DMAG_WIDTH        = 3 * ELEM_WIDTH;

   localparam int COF_LAT   = 4;
   localparam int DET_LAT   = 5;
   localparam int DIV_LAT   = ELEM_WIDTH + 2;
   localparam int BACK_LAT  = DIV_LAT + 1;
   localparam int TOTAL_LAT = COF_LAT + DET_LAT + BACK_LAT;

   typedef logic signed [ELEM_WIDTH-1:0]   elem_type;
   typedef logic [8:0][ELEM_WIDTH-1:0]     mat_type;
   typedef logic [THRESH_WIDTH-1:0]        thresh_type;

   typedef struct packed {
      elem_type in_r0c0;
      elem_type in_r0c1;
      elem_type in_r0c2;
      elem_type in_r1c0;
      elem_type in_r1c1;
      elem_type in_r1c2;
      elem_type in_r2c0;
      elem_type in_r2c1;
      elem_type in_r2c2;
   } req_type;

   typedef struct packed {
      elem_type out_r0c0;
      elem_type out_r0c1;
      elem_type out_r0c2;
      elem_type out_r1c0;
      elem_type out_r1c1;
      elem_type out_r1c2;
      elem_type out_r2c0;
      elem_type out_r2c1;
      elem_type out_r2c2;
      logic     singular;
      logic     saturated;
   } rsp_type;

   typedef struct packed {
      logic                            valid;
      mat_type                         mat;
      logic [8:0][CMAG_WIDTH-1:0]      cmag;
      logic [8:0]                      cneg;
   } cof_bus_type;

   typedef struct packed {
      logic                            valid;
      logic                            singular;
      mat_type                         mat;
      logic [8:0][CMAG_WIDTH-1:0]      cmag;
      logic [8:0]                      cneg;
      logic [DMAG_WIDTH-1:0]           dmag;
      logic                            dneg;
   } det_bus_type;

   // element index is row * 3 + column
   function automatic mat_type req_to_mat(req_type r);
      mat_type m;
      m[0] = r.in_r0c0;
      m[1] = r.in_r0c1;
      m[2] = r.in_r0c2;
      m[3] = r.in_r1c0;
      m[4] = r.in_r1c1;
      m[5] = r.in_r1c2;
      m[6] = r.in_r2c0;
      m[7] = r.in_r2c1;
      m[8] = r.in_r2c2;
      return m;
   endfunction

   function automatic rsp_type mat_to_rsp(mat_type m, logic singular, logic saturated);
      rsp_type r;
      r.out_r0c0  = m[0];
      r.out_r0c1  = m[1];
      r.out_r0c2  = m[2];
      r.out_r1c0  = m[3];
      r.out_r1c1  = m[4];
      r.out_r1c2  = m[5];
      r.out_r2c0  = m[6];
      r.out_r2c1  = m[7];
      r.out_r2c2  = m[8];
      r.singular  = singular;
      r.saturated = saturated;
      return r;
   endfunction

endpackage

// ===== rtl/core/mi3_cof.sv =====
// ---------------------------------------------------------------------------
// mi3_cof
// Input register, 18 products and the nine 2x2 cofactors in sign/magnitude.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_cof import mi3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  mat_type     in_mat,
   output cof_bus_type cof_out
);

   localparam int PW = 2 * ELEM_WIDTH;

   // cofactor i = m[A]*m[B] - m[C]*m[D]
   localparam int A_IDX [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
   localparam int B_IDX [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
   localparam int C_IDX [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
   localparam int D_IDX [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};

   logic [COF_LAT-1:0]  vld_ff;
   mat_type             mat_ff [COF_LAT];
   logic signed [PW-1:0] prod_p_ff [9];
   logic signed [PW-1:0] prod_q_ff [9];
   logic [PW:0]         cof_ff [9];
   logic [PW:0]         cabs [9];
   logic [8:0][PW-1:0]  cmag_ff;
   logic [8:0]          cneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[COF_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      mat_ff[0] <= in_mat;
      for (int k = 1; k < COF_LAT; k++) begin
         mat_ff[k] <= mat_ff[k-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         cabs[i] = cof_ff[i][PW] ? (~cof_ff[i] + 1'b1) : cof_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         prod_p_ff[i] <= $signed(mat_ff[0][A_IDX[i]]) * $signed(mat_ff[0][B_IDX[i]]);
         prod_q_ff[i] <= $signed(mat_ff[0][C_IDX[i]]) * $signed(mat_ff[0][D_IDX[i]]);
         cof_ff[i]    <= {prod_p_ff[i][PW-1], prod_p_ff[i]} -
                         {prod_q_ff[i][PW-1], prod_q_ff[i]};
         cmag_ff[i]   <= cabs[i][PW-1:0];
         cneg_ff[i]   <= cof_ff[i][PW];
      end
   end

   assign cof_out.valid = vld_ff[COF_LAT-1];
   assign cof_out.mat   = mat_ff[COF_LAT-1];
   assign cof_out.cmag  = cmag_ff;
   assign cof_out.cneg  = cneg_ff;

endmodule

// ===== rtl/core/mi3_det.sv =====
// ---------------------------------------------------------------------------
// mi3_det
// Determinant by first-row expansion and the singular decision.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_det import mi3_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  thresh_type  thresh,
   input  cof_bus_type cof_in,
   output det_bus_type det_out
);

   localparam int W     = ELEM_WIDTH;
   localparam int DDW   = DMAG_WIDTH + 2;
   localparam int SHIFT = 3 * FRAC_BITS - THRESH_FRAC;
   localparam int TW    = THRESH_WIDTH + SHIFT;
   localparam int CMPW  = (TW > DMAG_WIDTH) ? TW : DMAG_WIDTH;

   logic [DET_LAT-1:0]      vld_ff;
   cof_bus_type             car_ff [DET_LAT];
   logic [W-1:0]            emag [3];
   logic [2:0]              eneg;
   logic [2*W-1:0]          lo_ff [3];
   logic [2*W-1:0]          hi_ff [3];
   logic [2:0]              sg5_ff;
   logic [DMAG_WIDTH-1:0]   term_ff [3];
   logic [2:0]              sg6_ff;
   logic [DDW-1:0]          xt [3];
   logic [DDW-1:0]          det_ff;
   logic [DDW-1:0]          dabs;
   logic [DMAG_WIDTH-1:0]   dmag8_ff;
   logic                    dneg8_ff;
   logic [DMAG_WIDTH-1:0]   dmag9_ff;
   logic                    dneg9_ff;
   logic                    sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DET_LAT-2:0], cof_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      car_ff[0] <= cof_in;
      for (int k = 1; k < DET_LAT; k++) begin
         car_ff[k] <= car_ff[k-1];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         eneg[j] = cof_in.mat[j][W-1];
         emag[j] = eneg[j] ? (~cof_in.mat[j] + 1'b1) : cof_in.mat[j];
         // conditional negate folded into the three-way add
         xt[j]   = sg6_ff[j] ? ~{2'b00, term_ff[j]} : {2'b00, term_ff[j]};
      end
      dabs = det_ff[DDW-1] ? (~det_ff + 1'b1) : det_ff;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         // cofactors 0, 3, 6 pair with row 0; middle term subtracts
         lo_ff[j]   <= cof_in.cmag[3*j][W-1:0] * emag[j];
         hi_ff[j]   <= cof_in.cmag[3*j][2*W-1:W] * emag[j];
         sg5_ff[j]  <= cof_in.cneg[3*j] ^ eneg[j] ^ (j == 1);
         term_ff[j] <= (DMAG_WIDTH'(hi_ff[j]) << W) + DMAG_WIDTH'(lo_ff[j]);
         sg6_ff[j]  <= sg5_ff[j];
      end
      det_ff   <= xt[0] + xt[1] + xt[2] +
                  DDW'(sg6_ff[0]) + DDW'(sg6_ff[1]) + DDW'(sg6_ff[2]);
      dmag8_ff <= dabs[DMAG_WIDTH-1:0];
      dneg8_ff <= det_ff[DDW-1];
      dmag9_ff <= dmag8_ff;
      dneg9_ff <= dneg8_ff;
      sing_ff  <= (dmag8_ff == '0) || (CMPW'(dmag8_ff) < (CMPW'(thresh) << SHIFT));
   end

   assign det_out.valid    = vld_ff[DET_LAT-1];
   assign det_out.singular = sing_ff;
   assign det_out.mat      = car_ff[DET_LAT-1].mat;
   assign det_out.cmag     = car_ff[DET_LAT-1].cmag;
   assign det_out.cneg     = car_ff[DET_LAT-1].cneg;
   assign det_out.dmag     = dmag9_ff;
   assign det_out.dneg     = dneg9_ff;

endmodule

// ===== rtl/core/mi3_div.sv =====
// ---------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, with rounding
// offset and overflow detect for one inverse element.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_div import mi3_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter bit FLIP      = 1'b0
) (
   input  logic                  clock,
   input  logic [CMAG_WIDTH-1:0] cmag,
   input  logic                  cneg,
   input  logic [DMAG_WIDTH-1:0] dmag,
   input  logic                  dneg,
   output logic [ELEM_WIDTH-1:0] quot,
   output logic                  ovf,
   output logic                  neg
);

   localparam int W     = ELEM_WIDTH;
   localparam int NUM_W = CMAG_WIDTH + 2 * FRAC_BITS + 1;
   localparam int DEN_W = DMAG_WIDTH + W + 1;
   localparam int XW    = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;

   typedef logic [XW-1:0] wide_type;

   wide_type      num_ff;
   wide_type      den_ff;
   logic          neg0_ff;
   wide_type      rem_ff [W+1];
   wide_type      dsr_ff [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic [W:0]    ovf_ff;
   logic [W:0]    sg_ff;

   // numerator carries the half-divisor so the floor rounds to nearest
   always_ff @(posedge clock) begin
      num_ff    <= (wide_type'(cmag) << (2 * FRAC_BITS + 1)) + wide_type'(dmag);
      den_ff    <= wide_type'(dmag) << 1;
      neg0_ff   <= cneg ^ dneg ^ FLIP;
      rem_ff[0] <= num_ff;
      dsr_ff[0] <= den_ff;
      q_ff[0]   <= '0;
      ovf_ff[0] <= num_ff >= (den_ff << W);
      sg_ff[0]  <= neg0_ff;
   end

   for (genvar k = 1; k <= W; k++) begin : g_stage
      localparam int B = W - k;
      wide_type trial;
      assign trial = dsr_ff[k-1] << B;
      always_ff @(posedge clock) begin
         if (rem_ff[k-1] >= trial) begin
            rem_ff[k] <= rem_ff[k-1] - trial;
            q_ff[k]   <= q_ff[k-1] | (W'(1) << B);
         end else begin
            rem_ff[k] <= rem_ff[k-1];
            q_ff[k]   <= q_ff[k-1];
         end
         dsr_ff[k] <= dsr_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         sg_ff[k]  <= sg_ff[k-1];
      end
   end

   assign quot = q_ff[W];
   assign ovf  = ovf_ff[W];
   assign neg  = sg_ff[W];

endmodule

// ===== rtl/core/mi3_back.sv =====
// ---------------------------------------------------------------------------
// mi3_back
// Nine element dividers, control delay line, and the sign, saturation and
// singular-echo output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_back import mi3_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  det_bus_type det_in,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   localparam int W = ELEM_WIDTH;

   logic [8:0][W-1:0]  quot;
   logic [8:0]         ovf;
   logic [8:0]         neg;
   logic [DIV_LAT-1:0] vld_ff;
   logic [DIV_LAT-1:0] sing_ff;
   mat_type            mat_ff [DIV_LAT];
   mat_type            res;
   logic [8:0]         clip;
   logic [W-1:0]       lim [9];
   logic [W-1:0]       qs  [9];
   logic               strobe_ff;
   rsp_type            data_ff;

   for (genvar gi = 0; gi < 9; gi++) begin : g_div
      mi3_div #(
         .FRAC_BITS (FRAC_BITS),
         .FLIP      (1'(((gi / 3) + (gi % 3)) % 2))
      ) u_div (
         .clock (clock),
         .cmag  (det_in.cmag[gi]),
         .cneg  (det_in.cneg[gi]),
         .dmag  (det_in.dmag),
         .dneg  (det_in.dneg),
         .quot  (quot[gi]),
         .ovf   (ovf[gi]),
         .neg   (neg[gi])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[DIV_LAT-2:0], det_in.valid};
         strobe_ff <= vld_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      sing_ff   <= {sing_ff[DIV_LAT-2:0], det_in.singular};
      mat_ff[0] <= det_in.mat;
      for (int k = 1; k < DIV_LAT; k++) begin
         mat_ff[k] <= mat_ff[k-1];
      end
   end

   // negative side may reach the full -2^(W-1)
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         lim[i]  = neg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         clip[i] = ovf[i] || (quot[i] > lim[i]);
         qs[i]   = clip[i] ? lim[i] : quot[i];
         res[i]  = neg[i] ? (~qs[i] + 1'b1) : qs[i];
      end
   end

   always_ff @(posedge clock) begin
      if (sing_ff[DIV_LAT-1]) begin
         data_ff <= mat_to_rsp(mat_ff[DIV_LAT-1], 1'b1, 1'b0);
      end else begin
         data_ff <= mat_to_rsp(res, 1'b0, |clip);
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

endmodule

// ===== rtl/core/matrix_invert_3x3_top.sv =====
// ---------------------------------------------------------------------------
// matrix_invert_3x3_top
// 3x3 Q16.16 matrix inverse by adjugate over determinant, with singular
// detection against a programmable threshold.
// ---------------------------------------------------------------------------
// Fully pipelined: one matrix is taken on every cycle that start is high and
// busy is always low. The result strobes exactly ELEM_WIDTH + 12 cycles after
// the item is taken (44 at 32-bit elements), in order, and must be captured
// in that cycle since there is no backpressure. The latency is set by the
// element dividers, which resolve one quotient bit per stage. Write
// singular_threshold on the csr_ channel only while no item is in flight.
`timescale 1ns / 1ps

`include "matrix_invert_3x3_top_macros.svh"

module matrix_invert_3x3_top import mi3_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  thresh_type csr_wdata
);

   thresh_type  thresh_ff;
   logic        in_valid;
   cof_bus_type cof_bus;
   det_bus_type det_bus;

   // pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign in_valid  = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_WIDTH'(1);
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_wdata;
      end
   end

   mi3_cof u_cof (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_mat   (req_to_mat(req_data)),
      .cof_out  (cof_bus)
   );

   mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock   (clock),
      .reset   (reset),
      .thresh  (thresh_ff),
      .cof_in  (cof_bus),
      .det_out (det_bus)
   );

   mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .det_in     (det_bus),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `MI3_ASSERT(a_strobe_latency, clock, reset, rsp_strobe |-> $past(start, TOTAL_LAT), "result without item")
   `MI3_ASSERT(a_sing_no_sat, clock, reset, (rsp_strobe && rsp_data.singular) |-> !rsp_data.saturated, "singular item flagged saturated")
   `MI3_ASSERT(a_sing_echo, clock, reset, (rsp_strobe && rsp_data.singular) |-> (rsp_data.out_r1c1 == $past(req_data.in_r1c1, TOTAL_LAT)), "singular item not echoed")
   `MI3_ASSERT_NORST(a_quiet_after_reset, clock, $past(reset) |-> !rsp_strobe, "strobe right after reset")

endmodule
